[hdl/gcd_lcm_unit_defines.svh]
// Assertion macros for the gcd_lcm_unit RTL.
`ifndef GCD_LCM_UNIT_DEFINES_SVH
`define GCD_LCM_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define GCDL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gcd_lcm_unit assertion failed");

`define GCDL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gcd_lcm_unit assertion failed");

`else

`define GCDL_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define GCDL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hdl/gcdl_pkg.sv]
// Shared constants, state encoding and control/status types of the GCD/LCM unit.
package gcdl_pkg;

  localparam int WIDTH   = 16;
  localparam int IN_W    = 16;
  localparam int RES_W   = 32;
  localparam int K_W     = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam int CNT_W   = $clog2(WIDTH + 1);
  localparam int PROD_W  = 2 * WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic mul;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic zero_op;
    logic gcd_eq;
    logic lcm;
    logic div_done;
  } dp_status_t;

endpackage

[hdl/gcd_lcm_unit.sv]
// GCD / LCM unit: one 16-bit operand pair per transfer, one 32-bit result per
// transfer. The GCD is found with a binary (shift-and-subtract) iteration; the
// LCM then divides the first operand by the GCD in a restoring divider and
// multiplies the quotient by the second operand. One item is in work at a time,
// from transfer in to result. A zero operand returns result 0 with the error
// flag set. The result sits in an output register, so the next item is taken
// while a finished result still waits for its transfer out.
`include "gcd_lcm_unit_defines.svh"

module gcd_lcm_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [2*gcdl_pkg::IN_W-1:0]   in_tdata,   // operand_a, operand_b
  input  logic                          in_tuser,   // command
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [gcdl_pkg::RES_W-1:0]    out_tdata,  // result
  output logic                          out_tuser   // error
);

  gcdl_pkg::ctrl_cmd_t  cmd;
  gcdl_pkg::dp_status_t status;

  gcdl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .status     (status),
    .cmd        (cmd)
  );

  gcdl_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .status   (status),
    .res_r    (out_tdata),
    .err_r    (out_tuser)
  );

  `GCDL_ASSERT_SAME(a_err_zero_result, clk, rst_n, out_tvalid && out_tuser, out_tdata == '0)
  `GCDL_ASSERT_SAME(a_ok_nonzero, clk, rst_n, out_tvalid && !out_tuser, out_tdata != '0)
  `GCDL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `GCDL_ASSERT_SAME(a_one_cmd, clk, rst_n, 1'b1, $onehot0(cmd))

endmodule

[hdl/gcdl_dp.sv]
// Datapath: binary GCD, restoring divider, multiplier and result register.
module gcdl_dp (
  input  logic                           clk,
  input  gcdl_pkg::ctrl_cmd_t            cmd,
  input  logic [2*gcdl_pkg::IN_W-1:0]    in_tdata,
  input  logic                           in_tuser,
  output gcdl_pkg::dp_status_t           status,
  output logic [gcdl_pkg::RES_W-1:0]     res_r,
  output logic                           err_r
);

  localparam int W = gcdl_pkg::WIDTH;

  logic [W-1:0]                 a_r;
  logic [W-1:0]                 b_r;
  logic                         lcm_r;
  logic [W-1:0]                 x_r;
  logic [W-1:0]                 y_r;
  logic [gcdl_pkg::K_W-1:0]     k_r;
  logic [W-1:0]                 g_r;
  logic [W:0]                   rem_r;
  logic [W-1:0]                 quo_r;
  logic [gcdl_pkg::CNT_W-1:0]   cnt_r;
  logic [gcdl_pkg::PROD_W-1:0]  prod_r;

  logic [W-1:0]                 x_nxt;
  logic [W-1:0]                 y_nxt;
  logic [gcdl_pkg::K_W-1:0]     k_nxt;
  logic [W:0]                   shifted;
  logic [W:0]                   diff;
  logic [gcdl_pkg::RES_W-1:0]   res_nxt;
  logic                         zero_op;

  assign zero_op = (a_r == '0) || (b_r == '0);

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    k_nxt = k_r;
    if (!x_r[0] && !y_r[0]) begin
      x_nxt = x_r >> 1;
      y_nxt = y_r >> 1;
      k_nxt = k_r + 1'b1;
    end else if (!x_r[0]) begin
      x_nxt = x_r >> 1;
    end else if (!y_r[0]) begin
      y_nxt = y_r >> 1;
    end else if (x_r > y_r) begin
      x_nxt = (x_r - y_r) >> 1;
    end else begin
      y_nxt = (y_r - x_r) >> 1;
    end
  end

  assign shifted = {rem_r[W-1:0], quo_r[W-1]};
  assign diff    = shifted - {1'b0, g_r};

  always_comb begin
    if (zero_op) begin
      res_nxt = '0;
    end else if (lcm_r) begin
      res_nxt = gcdl_pkg::RES_W'(prod_r);
    end else begin
      res_nxt = gcdl_pkg::RES_W'(g_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r   <= W'(in_tdata[gcdl_pkg::IN_W-1:0]);
      b_r   <= W'(in_tdata[2*gcdl_pkg::IN_W-1:gcdl_pkg::IN_W]);
      x_r   <= W'(in_tdata[gcdl_pkg::IN_W-1:0]);
      y_r   <= W'(in_tdata[2*gcdl_pkg::IN_W-1:gcdl_pkg::IN_W]);
      k_r   <= '0;
      lcm_r <= in_tuser;
    end else if (cmd.gcd_step) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      k_r <= k_nxt;
    end
    if (cmd.div_init) begin
      g_r   <= x_r << k_r;
      rem_r <= '0;
      quo_r <= a_r;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      if (!diff[W]) begin
        rem_r <= diff;
        quo_r <= {quo_r[W-2:0], 1'b1};
      end else begin
        rem_r <= shifted;
        quo_r <= {quo_r[W-2:0], 1'b0};
      end
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.mul) begin
      prod_r <= gcdl_pkg::PROD_W'(quo_r) * gcdl_pkg::PROD_W'(b_r);
    end
    if (cmd.load_out) begin
      res_r <= res_nxt;
      err_r <= zero_op;
    end
  end

  always_comb begin
    status.zero_op  = zero_op;
    status.gcd_eq   = (x_r == y_r);
    status.lcm      = lcm_r;
    status.div_done = (cnt_r == gcdl_pkg::CNT_W'(W));
  end

endmodule

[hdl/gcdl_ctrl.sv]
// Controller: sequences load, GCD, divide, multiply and result hand-off.
module gcdl_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  input  gcdl_pkg::dp_status_t  status,
  output gcdl_pkg::ctrl_cmd_t   cmd
);

  gcdl_pkg::state_t state_r;
  gcdl_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gcdl_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = gcdl_pkg::ST_GCD;
      end
      gcdl_pkg::ST_GCD: begin
        if (status.zero_op) begin
          state_nxt = gcdl_pkg::ST_DONE;
        end else if (status.gcd_eq) begin
          state_nxt = status.lcm ? gcdl_pkg::ST_DIV : gcdl_pkg::ST_DONE;
        end
      end
      gcdl_pkg::ST_DIV: begin
        if (status.div_done) state_nxt = gcdl_pkg::ST_MUL;
      end
      gcdl_pkg::ST_MUL: begin
        state_nxt = gcdl_pkg::ST_DONE;
      end
      gcdl_pkg::ST_DONE: begin
        if (out_free) state_nxt = gcdl_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = gcdl_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      gcdl_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      gcdl_pkg::ST_GCD: begin
        cmd.div_init = !status.zero_op && status.gcd_eq;
        cmd.gcd_step = !status.zero_op && !status.gcd_eq;
      end
      gcdl_pkg::ST_DIV: begin
        cmd.div_step = !status.div_done;
      end
      gcdl_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
      end
      gcdl_pkg::ST_DONE: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gcdl_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for gcd_lcm_unit: directed and random operand pairs, checked per transfer.
module tb;

  localparam logic CMD_GCD      = 1'b0;
  localparam logic CMD_LCM      = 1'b1;
  localparam int   CYCLE_LIMIT  = 1_000_000;
  localparam int   SETTLE_CYCLES = 3 * gcdl_pkg::WIDTH + 20;
  localparam int   PHASE_ITEMS  = 305;
  localparam int   HOLD_CYCLES  = 400;

  typedef struct {
    logic                      cmd;
    logic [gcdl_pkg::IN_W-1:0] a;
    logic [gcdl_pkg::IN_W-1:0] b;
  } operand_pair_t;

  typedef struct {
    logic                       cmd;
    logic [gcdl_pkg::RES_W-1:0] result;
    logic                       error;
  } answer_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [2*gcdl_pkg::IN_W-1:0]   in_tdata = '0;
  logic                          in_tuser = 1'b0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [gcdl_pkg::RES_W-1:0]    out_tdata;
  logic                          out_tuser;
  logic                          rx_hold_on = 1'b0;

  operand_pair_t pending_pairs[$];
  answer_t       predicted_answers[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int cycle_count = 0;
  int n_fail      = 0;
  int n_gcd       = 0;
  int n_lcm       = 0;
  int n_zero      = 0;

  gcd_lcm_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic answer_t gcd_lcm_of(input logic cmd,
                                         input logic [gcdl_pkg::IN_W-1:0] a,
                                         input logic [gcdl_pkg::IN_W-1:0] b);
    logic [gcdl_pkg::RES_W-1:0] x;
    logic [gcdl_pkg::RES_W-1:0] y;
    logic [gcdl_pkg::RES_W-1:0] r;
    answer_t                    ans;
    ans.cmd = cmd;
    if (a == '0 || b == '0) begin
      ans.result = '0;
      ans.error  = 1'b1;
      return ans;
    end
    x = gcdl_pkg::RES_W'(a);
    y = gcdl_pkg::RES_W'(b);
    while (y != '0) begin
      r = x % y;
      x = y;
      y = r;
    end
    ans.error  = 1'b0;
    ans.result = (cmd == CMD_GCD) ? x :
                 (gcdl_pkg::RES_W'(a) / x) * gcdl_pkg::RES_W'(b);
    return ans;
  endfunction

  function automatic operand_pair_t random_pair();
    operand_pair_t p;
    int            kind;
    int            g;
    p.cmd = 1'($urandom_range(1));
    kind  = $urandom_range(99);
    if (kind < 6) begin
      p.a = gcdl_pkg::IN_W'($urandom());
      p.b = gcdl_pkg::IN_W'($urandom());
      case ($urandom_range(2))
        0: p.a = '0;
        1: p.b = '0;
        default: begin
          p.a = '0;
          p.b = '0;
        end
      endcase
    end else if (kind < 40) begin
      p.a = gcdl_pkg::IN_W'($urandom());
      p.b = gcdl_pkg::IN_W'($urandom());
    end else if (kind < 70) begin
      // shared factor, so the gcd is more than 1
      g   = $urandom_range(2, 1000);
      p.a = gcdl_pkg::IN_W'(g * $urandom_range(1, 65535 / g));
      p.b = gcdl_pkg::IN_W'(g * $urandom_range(1, 65535 / g));
    end else begin
      p.a = 16'($urandom()) >> $urandom_range(15);
      p.b = 16'($urandom()) >> $urandom_range(15);
    end
    return p;
  endfunction

  task automatic add_pair(input logic cmd, input logic [gcdl_pkg::IN_W-1:0] a,
                          input logic [gcdl_pkg::IN_W-1:0] b);
    operand_pair_t p;
    p.cmd = cmd;
    p.a   = a;
    p.b   = b;
    pending_pairs.push_back(p);
  endtask

  task automatic add_random(input int n);
    repeat (n) pending_pairs.push_back(random_pair());
  endtask

  task automatic wait_drained();
    while (pending_pairs.size() != 0 || in_tvalid || predicted_answers.size() != 0)
      @(negedge clk);
  endtask

  // driver: present the next pair once the current transfer is done
  always @(posedge clk) begin : drive_p
    operand_pair_t p;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        predicted_answers.push_back(gcd_lcm_of(in_tuser, in_tdata[gcdl_pkg::IN_W-1:0],
                                               in_tdata[2*gcdl_pkg::IN_W-1:gcdl_pkg::IN_W]));
      if (!in_tvalid || in_tready) begin
        if (pending_pairs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          p = pending_pairs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {p.b, p.a};
          in_tuser  <= p.cmd;
        end else begin
          in_tvalid <= 1'b0;
          in_tdata  <= $urandom();
          in_tuser  <= 1'($urandom_range(1));
        end
      end
    end
  end

  // monitor: check each result transfer, then pick the next ready
  always @(posedge clk) begin : check_p
    answer_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (predicted_answers.size() == 0) begin
          $error("unexpected result transfer: result %0d error %0b", out_tdata, out_tuser);
          n_fail++;
        end else begin
          want = predicted_answers.pop_front();
          if (out_tdata !== want.result) begin
            $error("result: expected %0d, actual %0d", want.result, out_tdata);
            n_fail++;
          end
          if (out_tuser !== want.error) begin
            $error("error: expected %0b, actual %0b", want.error, out_tuser);
            n_fail++;
          end
          if (want.error)
            n_zero++;
          else if (want.cmd == CMD_GCD)
            n_gcd++;
          else
            n_lcm++;
        end
      end
      if (rx_hold_on) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    add_pair(CMD_GCD, 16'd0,     16'd0);
    add_pair(CMD_LCM, 16'd0,     16'd0);
    add_pair(CMD_GCD, 16'd0,     16'd1234);
    add_pair(CMD_LCM, 16'hFFFF,  16'd0);
    add_pair(CMD_GCD, 16'd1,     16'd1);
    add_pair(CMD_LCM, 16'd1,     16'd1);
    add_pair(CMD_GCD, 16'hFFFF,  16'hFFFF);
    add_pair(CMD_LCM, 16'hFFFF,  16'hFFFF);
    add_pair(CMD_GCD, 16'hFFFF,  16'hFFFE);
    add_pair(CMD_LCM, 16'hFFFF,  16'hFFFE);
    add_pair(CMD_LCM, 16'd65521, 16'd65519);
    add_pair(CMD_GCD, 16'd65521, 16'd65519);
    add_pair(CMD_GCD, 16'h8000,  16'h4000);
    add_pair(CMD_LCM, 16'h8000,  16'h4000);
    add_pair(CMD_LCM, 16'h8000,  16'hFFFF);
    add_pair(CMD_GCD, 16'd1,     16'hFFFF);
    add_pair(CMD_LCM, 16'hFFFF,  16'd1);
    add_pair(CMD_GCD, 16'd12,    16'd18);
    add_pair(CMD_LCM, 16'd12,    16'd18);
    add_pair(CMD_GCD, 16'd7,     16'd49000);
    add_pair(CMD_LCM, 16'd49000, 16'd7);
    add_pair(CMD_GCD, 16'hAAAA,  16'h5555);
    wait_drained();

    add_random(PHASE_ITEMS);
    wait_drained();

    tx_idle_pct = 56;
    add_random(PHASE_ITEMS);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 56;
    add_random(PHASE_ITEMS);
    wait_drained();

    // hold the receiver while the sender keeps offering, so the input backs up
    rx_idle_pct = 0;
    fork
      begin : hold_p
        rx_hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold_on = 1'b0;
      end
    join_none
    add_random(20);
    wait_drained();

    tx_idle_pct = 13;
    rx_idle_pct = 13;
    add_random(PHASE_ITEMS);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (predicted_answers.size() != 0) begin
      $error("%0d expected results never arrived", predicted_answers.size());
      n_fail++;
    end
    $display("checked %0d gcd, %0d lcm and %0d zero-operand results", n_gcd, n_lcm, n_zero);
    $display("under free flow, sender gaps, receiver stalls and a long output hold-off");
    if (n_fail == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
